// ===== rtl/core/hap_pkg.sv =====
// ----------------------------------------------------------------------------
// hap_pkg
// Shared types, register indexes and constants of the adaptive predictor.
// ----------------------------------------------------------------------------
package hap_pkg;

	// default configuration of the predictor
	localparam int PredBandsDef  = 3;
	localparam int SampleBitsDef = 16;
	localparam int WeightResDef  = 19;

	// configuration port
	localparam int CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MAX_ERROR       = 3'd0,
		REG_WEIGHT_EXP_MIN  = 3'd1,
		REG_WEIGHT_EXP_MAX  = 3'd2,
		REG_WEIGHT_INC_LOG  = 3'd3,
		REG_POSITION_OFFSET = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic        [7:0]  max_error;
		logic signed [4:0]  weight_exp_min;
		logic signed [4:0]  weight_exp_max;
		logic        [3:0]  weight_inc_log;
		logic        [15:0] position_offset;
	} cfg_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAC,
		ST_PRED,
		ST_RESID,
		ST_DIV,
		ST_QUANT,
		ST_MAP,
		ST_ERR,
		ST_UPD,
		ST_DONE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load_item;
		logic cnt_clr;
		logic cnt_inc;
		logic mac_en;
		logic pred_en;
		logic resid_en;
		logic div_en;
		logic quant_en;
		logic map_en;
		logic err_en;
		logic upd_en;
		logic out_load;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic t_pos;
		logic cnt_last;
		logic div_last;
	} status_t;

	// reset weight of tap idx: 7/8 of 2^wr, then each previous divided by 8
	function automatic longint init_weight(input int idx, input int wr);
		longint w;
		w = ((longint'(1) << wr) * 7) / 8;
		for (int i = 0; i < idx; i++) begin
			w = w / 8;
		end
		return w;
	endfunction

endpackage

// ===== rtl/core/hyperspectral_adaptive_predictor_top.sv =====
// ----------------------------------------------------------------------------
// hyperspectral_adaptive_predictor_top
// Reduced-mode adaptive sample predictor with column-oriented local sums.
// ----------------------------------------------------------------------------
// One item at a time. With n = min(band, PRED_BANDS) taps in use, an item is
// accepted, then passes through a multiply-accumulate over the n taps on one
// shared multiplier, prediction and residual, a one-bit-per-cycle divider of
// max(SAMPLE_BITS,8)+1 quotient bits, quantizing and index mapping, the error
// sign and update exponent, a weight update over the same tap registers and
// the hand-over of the result. At position zero the divider, error and update
// steps are skipped. The hand-over waits while a previous result is still
// stalled in the output register, and the next item is taken while the result
// waits there. Configuration writes take effect at once, so write them only
// while no item is in flight.
module hyperspectral_adaptive_predictor_top
	import hap_pkg::*;
#(
	parameter int PRED_BANDS  = PredBandsDef,
	parameter int SAMPLE_BITS = SampleBitsDef,
	parameter int WEIGHT_RES  = WeightResDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        sample,
	input  logic [15:0]        above_sample,
	input  logic [23:0]        position,
	input  logic [15:0]        band,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        mapped_index,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [31:0]        cfg_data
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	// configuration registers
	hap_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid && cfg_ready),
		.wr_idx  (cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	// sequencer
	hap_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath
	hap_dp #(
		.PRED_BANDS  (PRED_BANDS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.WEIGHT_RES  (WEIGHT_RES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg),
		.sample       (sample),
		.above_sample (above_sample),
		.position     (position),
		.band         (band),
		.status       (status),
		.mapped_index (mapped_index)
	);

endmodule

// ===== rtl/core/hap_cfg.sv =====
// ----------------------------------------------------------------------------
// hap_cfg
// Configuration registers of the adaptive predictor.
// ----------------------------------------------------------------------------
module hap_cfg
	import hap_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [CfgIdxW-1:0] wr_idx,
	input  logic [31:0]        wr_data,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_error       <= 8'd0;
			cfg_q.weight_exp_min  <= -5'sd1;
			cfg_q.weight_exp_max  <= 5'sd3;
			cfg_q.weight_inc_log  <= 4'd6;
			cfg_q.position_offset <= 16'd5;
		end else if (wr_en) begin
			case (wr_idx)
				REG_MAX_ERROR:       cfg_q.max_error       <= wr_data[7:0];
				REG_WEIGHT_EXP_MIN:  cfg_q.weight_exp_min  <= wr_data[4:0];
				REG_WEIGHT_EXP_MAX:  cfg_q.weight_exp_max  <= wr_data[4:0];
				REG_WEIGHT_INC_LOG:  cfg_q.weight_inc_log  <= wr_data[3:0];
				REG_POSITION_OFFSET: cfg_q.position_offset <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/hap_ctrl.sv =====
// ----------------------------------------------------------------------------
// hap_ctrl
// Sequencer of the adaptive predictor: steps one item through the datapath.
// ----------------------------------------------------------------------------
module hap_ctrl
	import hap_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_MAC;
			ST_MAC:   if (status.cnt_last) state_d = ST_PRED;
			ST_PRED:  state_d = ST_RESID;
			ST_RESID: state_d = status.t_pos ? ST_DIV : ST_QUANT;
			ST_DIV:   if (status.div_last) state_d = ST_QUANT;
			ST_QUANT: state_d = ST_MAP;
			ST_MAP:   state_d = status.t_pos ? ST_ERR : ST_DONE;
			ST_ERR:   state_d = ST_UPD;
			ST_UPD:   if (status.cnt_last) state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load_item = in_valid;
				cmd.cnt_clr   = in_valid;
			end
			ST_MAC: begin
				cmd.mac_en  = 1'b1;
				cmd.cnt_inc = !status.cnt_last;
			end
			ST_PRED:  cmd.pred_en = 1'b1;
			ST_RESID: begin
				cmd.resid_en = 1'b1;
				cmd.cnt_clr  = 1'b1;
			end
			ST_DIV: begin
				cmd.div_en  = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			ST_QUANT: cmd.quant_en = 1'b1;
			ST_MAP:   cmd.map_en = 1'b1;
			ST_ERR: begin
				cmd.err_en  = 1'b1;
				cmd.cnt_clr = 1'b1;
			end
			ST_UPD: begin
				cmd.upd_en  = 1'b1;
				cmd.cnt_inc = !status.cnt_last;
			end
			ST_DONE:  cmd.out_load = out_free;
			default:  cmd = '0;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/hap_dp.sv =====
// ----------------------------------------------------------------------------
// hap_dp
// Datapath of the adaptive predictor: dot product, prediction, quantizer,
// index mapping and weight update, with the history and weight registers.
// ----------------------------------------------------------------------------
module hap_dp
	import hap_pkg::*;
#(
	parameter int PRED_BANDS  = PredBandsDef,
	parameter int SAMPLE_BITS = SampleBitsDef,
	parameter int WEIGHT_RES  = WeightResDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  cfg_t        cfg,
	input  logic [15:0] sample,
	input  logic [15:0] above_sample,
	input  logic [23:0] position,
	input  logic [15:0] band,
	output status_t     status,
	output logic [15:0] mapped_index
);

	localparam int SB      = SAMPLE_BITS;
	localparam int WR      = WEIGHT_RES;
	localparam int P_SLOTS = (PRED_BANDS > 0) ? PRED_BANDS : 1;
	localparam int IDX_W   = (P_SLOTS > 1) ? $clog2(P_SLOTS) : 1;
	localparam int DIFF_W  = SB + 3;
	localparam int W_W     = WR + 3;
	localparam int PROD_W  = DIFF_W + W_W;
	localparam int ACC_W   = PROD_W + 5;
	localparam int NUM_W   = ((SB > 8) ? SB : 8) + 1;
	localparam int Q_W     = NUM_W + 1;
	localparam int MAP_W   = NUM_W + 2;
	localparam int QS_W    = Q_W + 10;
	localparam int CNT_MAX = (PRED_BANDS > NUM_W) ? PRED_BANDS : NUM_W;
	localparam int CNT_W   = $clog2(CNT_MAX + 1);
	localparam int RHO_W   = 7;
	localparam int DELTA_W = DIFF_W + 25;
	localparam int SUM_W   = DELTA_W + 1;
	localparam int TD_W    = 26;

	localparam logic [SB-1:0]           SMAX   = {SB{1'b1}};
	localparam logic [SB-1:0]           SMID   = SB'(1) << (SB - 1);
	localparam logic signed [ACC_W-1:0] HR_HI  =
		(ACC_W'(SMAX) << (WR + 2)) + (ACC_W'(1) << (WR + 1));
	localparam logic signed [SUM_W-1:0] W_HI   = (SUM_W'(1) << (WR + 2)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] W_LO   = -(SUM_W'(1) << (WR + 2));
	localparam logic signed [RHO_W-1:0] RHO_OFS = RHO_W'(SAMPLE_BITS - WEIGHT_RES);

	// item registers
	logic        [SB-1:0]      s_q;
	logic        [SB-1:0]      above_q;
	logic        [23:0]        t_q;
	logic                      t_pos_q;
	logic                      z_pos_q;
	logic        [CNT_W-1:0]   used_q;
	logic signed [DIFF_W-1:0]  cdiff_q;
	logic        [CNT_W-1:0]   cnt_q;
	logic        [IDX_W-1:0]   idx;

	// state
	logic signed [DIFF_W-1:0]  hist_q [P_SLOTS];
	logic signed [W_W-1:0]     w_q    [P_SLOTS];
	logic        [SB-1:0]      last_q;

	// working registers
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic        [SB:0]        dr_q;
	logic signed [SB:0]        resid_q;
	logic        [SB-1:0]      mag_q;
	logic        [8:0]         rem_q;
	logic        [NUM_W-1:0]   quo_q;
	logic signed [Q_W-1:0]     q_q;
	logic        [NUM_W-1:0]   aq_q;
	logic        [MAP_W-1:0]   mapped_q;
	logic signed [QS_W-1:0]    qstep_q;
	logic                      neg_q;
	logic signed [RHO_W-1:0]   rho_q;
	logic        [15:0]        out_q;

	logic [CNT_W-1:0] used_d;
	assign used_d = (band < 16'(PRED_BANDS)) ? band[CNT_W-1:0] : CNT_W'(PRED_BANDS);
	assign idx    = cnt_q[IDX_W-1:0];

	assign status.t_pos    = t_pos_q;
	assign status.cnt_last = (cnt_q == used_q);
	assign status.div_last = (cnt_q == CNT_W'(NUM_W - 1));

	// tap product
	logic signed [PROD_W-1:0] mult;
	assign mult = PROD_W'(hist_q[idx]) * PROD_W'(w_q[idx]);

	// high-resolution prediction, clipped at both ends
	logic signed [ACC_W-1:0] hr, hr_c;
	logic        [SB:0]      dr_d;
	assign hr   = acc_q + (ACC_W'(above_q) << (WR + 2)) + (ACC_W'(1) << (WR + 1));
	assign hr_c = hr[ACC_W-1] ? '0 : ((hr > HR_HI) ? HR_HI : hr);
	always_comb begin
		if (t_pos_q) begin
			dr_d = hr_c[WR+1 +: SB+1];
		end else if (z_pos_q) begin
			dr_d = {last_q, 1'b0};
		end else begin
			dr_d = {SMID, 1'b0};
		end
	end

	// residual and quantizer numerator
	logic        [SB-1:0]    pred;
	logic signed [SB:0]      resid;
	logic        [SB:0]      mag_w;
	logic        [NUM_W-1:0] num;
	assign pred  = dr_q[SB:1];
	assign resid = $signed({1'b0, s_q}) - $signed({1'b0, pred});
	assign mag_w = resid[SB] ? (SB+1)'(-resid) : resid;
	assign num   = NUM_W'(mag_w[SB-1:0]) + NUM_W'(cfg.max_error);

	// restoring divider step by 2*max_error+1
	logic [8:0] step;
	logic [9:0] rem_sh;
	logic       div_ge;
	assign step   = {cfg.max_error, 1'b1};
	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign div_ge = (rem_sh >= {1'b0, step});

	// signed quantizer index
	logic signed [Q_W-1:0] aq_s, q_d;
	assign aq_s = $signed({1'b0, quo_q});
	always_comb begin
		if (t_pos_q) begin
			q_d = resid_q[SB] ? -aq_s : aq_s;
		end else begin
			q_d = Q_W'(resid_q);
		end
	end

	// index mapping
	logic        [SB-1:0]    theta;
	logic signed [Q_W:0]     sq;
	logic        [MAP_W-1:0] mapped_d;
	assign theta = (pred < (SMAX - pred)) ? pred : (SMAX - pred);
	assign sq    = dr_q[0] ? -(Q_W+1)'(q_q) : (Q_W+1)'(q_q);
	always_comb begin
		if (aq_q > NUM_W'(theta)) begin
			mapped_d = MAP_W'(aq_q) + MAP_W'(theta);
		end else if (!sq[Q_W] && (sq <= $signed({2'b0, NUM_W'(theta)}))) begin
			mapped_d = MAP_W'(aq_q) << 1;
		end else begin
			mapped_d = (MAP_W'(aq_q) << 1) - MAP_W'(1);
		end
	end

	// bin center, error sign and update exponent
	logic signed [QS_W:0]     cen;
	logic        [SB-1:0]     center;
	logic signed [TD_W-1:0]   tdiff, tsh, rho0, rho1, emin, emax;
	logic signed [RHO_W-1:0]  rho_d;
	assign cen    = (QS_W+1)'($signed({1'b0, pred})) + (QS_W+1)'(qstep_q);
	assign center = cen[QS_W] ? '0 : ((cen > (QS_W+1)'(SMAX)) ? SMAX : cen[SB-1:0]);
	assign emin   = TD_W'(cfg.weight_exp_min);
	assign emax   = TD_W'(cfg.weight_exp_max);
	assign tdiff  = $signed({2'b0, t_q}) - $signed({10'b0, cfg.position_offset});
	assign tsh    = tdiff >>> cfg.weight_inc_log;
	assign rho0   = emin + tsh;
	assign rho1   = (rho0 > emax) ? emax : ((rho0 < emin) ? emin : rho0);
	assign rho_d  = $signed(rho1[RHO_W-1:0]) + RHO_OFS;

	// weight update of one tap
	logic signed [DELTA_W-1:0] u, one_sh, pos_sum, neg_sum, delta;
	logic        [RHO_W-1:0]   nrho;
	logic signed [SUM_W-1:0]   wsum, wnew;
	assign u       = neg_q ? -DELTA_W'(hist_q[idx]) : DELTA_W'(hist_q[idx]);
	assign nrho    = RHO_W'(-rho_q);
	assign one_sh  = DELTA_W'(1) << rho_q[RHO_W-2:0];
	assign pos_sum = u + one_sh;
	assign neg_sum = (u <<< nrho) + DELTA_W'(1);
	assign delta   = rho_q[RHO_W-1] ? (neg_sum >>> 1) : (pos_sum >>> (rho_q[RHO_W-2:0] + 1));
	assign wsum    = SUM_W'(w_q[idx]) + SUM_W'(delta);
	assign wnew    = (wsum > W_HI) ? W_HI : ((wsum < W_LO) ? W_LO : wsum);

	// item capture and working registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			s_q     <= sample[SB-1:0];
			above_q <= above_sample[SB-1:0];
			t_q     <= position;
			t_pos_q <= (position != 24'd0);
			z_pos_q <= (band != 16'd0);
			used_q  <= used_d;
			cdiff_q <= {$signed({1'b0, sample[SB-1:0]}) - $signed({1'b0, above_sample[SB-1:0]}),
				2'b00};
			prod_q  <= '0;
			acc_q   <= '0;
		end
		if (cmd.mac_en) begin
			prod_q <= status.cnt_last ? '0 : mult;
			acc_q  <= acc_q + ACC_W'(prod_q);
		end
		if (cmd.pred_en) begin
			dr_q <= dr_d;
		end
		if (cmd.resid_en) begin
			resid_q <= resid;
			mag_q   <= mag_w[SB-1:0];
			rem_q   <= '0;
			quo_q   <= num;
		end
		if (cmd.div_en) begin
			rem_q <= div_ge ? 9'(rem_sh - {1'b0, step}) : rem_sh[8:0];
			quo_q <= {quo_q[NUM_W-2:0], div_ge};
		end
		if (cmd.quant_en) begin
			q_q  <= q_d;
			aq_q <= t_pos_q ? quo_q : NUM_W'(mag_q);
		end
		if (cmd.map_en) begin
			mapped_q <= mapped_d;
			qstep_q  <= QS_W'(q_q) * QS_W'($signed({1'b0, step}));
		end
		if (cmd.err_en) begin
			neg_q <= ({center, 1'b0} < dr_q);
			rho_q <= rho_d;
		end
		if (cmd.out_load) begin
			out_q <= 16'(mapped_q);
		end
	end

	// counter shared by taps and divider steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// predictor state: history, weights, previous sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < P_SLOTS; i++) begin
				hist_q[i] <= '0;
				w_q[i]    <= W_W'(init_weight(i, WEIGHT_RES));
			end
			last_q <= '0;
		end else begin
			if (cmd.resid_en) begin
				last_q <= s_q;
			end
			if (cmd.upd_en && !status.cnt_last) begin
				w_q[idx] <= wnew[W_W-1:0];
			end
			if (cmd.out_load && (PRED_BANDS > 0)) begin
				for (int i = P_SLOTS - 1; i > 0; i--) begin
					hist_q[i] <= hist_q[i-1];
				end
				hist_q[0] <= cdiff_q;
			end
		end
	end

	assign mapped_index = out_q;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks the adaptive predictor against an in-bench model of its prediction,
// quantizing, index mapping and weight adaptation, under random idling.
// ----------------------------------------------------------------------------
module tb;
	import hap_pkg::*;

	localparam int NB   = PredBandsDef;
	localparam int SB   = SampleBitsDef;
	localparam int WR   = WeightResDef;
	localparam longint SMAX = (longint'(1) << SB) - 1;
	localparam longint SMID = longint'(1) << (SB - 1);
	localparam longint WLIM = longint'(1) << (WR + 2);
	localparam int WDOG = 20000;

	// model of the predictor: state, registers and the expected index queue
	class index_scoreboard;
		logic [7:0]        m_err;
		logic signed [4:0] e_min;
		logic signed [4:0] e_max;
		logic [3:0]        inc_log;
		logic [15:0]       p_off;
		longint            dhist [NB];
		longint            wvec [NB];
		longint            prev_s;
		logic [15:0]       pending [$];
		int                errors;

		function new();
			m_err = 0; e_min = -1; e_max = 3; inc_log = 6; p_off = 5;
			prev_s = 0; errors = 0;
			for (int i = 0; i < NB; i++) begin
				dhist[i] = 0;
				wvec[i] = init_w(i);
			end
		endfunction

		function longint init_w(int idx);
			longint w;
			w = ((longint'(1) << WR) * 7) / 8;
			for (int i = 0; i < idx; i++) w = w / 8;
			return w;
		endfunction

		function longint fshr(longint x, int s);
			return x >>> s;
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] d);
			case (idx)
				REG_MAX_ERROR:       m_err = d[7:0];
				REG_WEIGHT_EXP_MIN:  e_min = d[4:0];
				REG_WEIGHT_EXP_MAX:  e_max = d[4:0];
				REG_WEIGHT_INC_LOG:  inc_log = d[3:0];
				REG_POSITION_OFFSET: p_off = d[15:0];
				default: ;
			endcase
		endfunction

		// predict one item and queue its mapped index
		function void note_item(logic [15:0] smp, logic [15:0] abv, logic [23:0] pos,
				logic [15:0] bnd);
			longint s, lsum, cd, m, stp, nused, dot, hr, dr, pr, res, q, aq, th, sq, mp;
			longint ctr, er, sg, rho, u, dl, t;
			s = smp; lsum = 4 * longint'(abv); cd = 4 * s - lsum; t = pos;
			m = m_err; stp = 2 * m + 1;
			nused = bnd < NB ? bnd : NB;
			dot = 0;
			for (int i = 0; i < nused; i++) dot += dhist[i] * wvec[i];
			hr = dot + (longint'(1) << WR) * (lsum - 4 * SMID) + (longint'(1) << (WR + 2)) * SMID
				+ (longint'(1) << (WR + 1));
			hr = clip(hr, 0, (longint'(1) << (WR + 2)) * SMAX + (longint'(1) << (WR + 1)));
			if (t > 0) dr = hr >>> (WR + 1);
			else dr = (bnd > 0) ? 2 * prev_s : 2 * SMID;
			pr = dr / 2;
			prev_s = s;
			res = s - pr;
			if (t > 0) begin
				aq = ((res < 0 ? -res : res) + m) / stp;
				q = res < 0 ? -aq : aq;
			end else q = res;
			aq = q < 0 ? -q : q;
			th = pr < SMAX - pr ? pr : SMAX - pr;
			sq = dr[0] ? -q : q;
			if (aq > th) mp = aq + th;
			else if (sq >= 0 && sq <= th) mp = 2 * aq;
			else mp = 2 * aq - 1;
			// sign-error weight adaptation
			if (t > 0) begin
				ctr = clip(pr + q * stp, 0, SMAX);
				er = 2 * ctr - dr;
				sg = er < 0 ? -1 : 1;
				rho = longint'(e_min) + fshr(t - longint'(p_off), inc_log);
				if (rho > e_max) rho = e_max;
				else if (rho < e_min) rho = e_min;
				rho = rho + SB - WR;
				for (int i = 0; i < nused; i++) begin
					u = sg * dhist[i];
					if (rho >= 0) dl = fshr(u + (longint'(1) << rho), int'(rho + 1));
					else dl = fshr(u * (longint'(1) << (-rho)) + 1, 1);
					wvec[i] = clip(wvec[i] + dl, -WLIM, WLIM - 1);
				end
			end
			for (int i = NB - 1; i > 0; i--) dhist[i] = dhist[i - 1];
			dhist[0] = cd;
			pending.push_back(mp[15:0]);
		endfunction

		function void check_index(logic [15:0] got);
			logic [15:0] want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected item: mapped_index=%0d", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("mapped_index mismatch: expected %0d, got %0d", want, got);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_stall = 0, cfg_valid = 0;
	logic [15:0] sample = 0, above_sample = 0, band = 0;
	logic [23:0] position = 0;
	logic in_stall, out_valid, cfg_ready;
	logic [15:0] mapped_index;
	logic [CfgIdxW-1:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;

	index_scoreboard sb = new();
	bit no_idle = 0;
	bit hold_rx = 0;
	int quiet = 0;

	hyperspectral_adaptive_predictor_top u_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// output side: random stalls, check each accepted item
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_index(mapped_index);
	end

	always @(negedge clk) begin
		if (hold_rx) out_stall <= 1;
		else out_stall <= !no_idle && ($urandom_range(99) < 9);
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > WDOG) begin
			$display("FAIL hyperspectral_adaptive_predictor_top");
			$finish;
		end
	end

	task automatic write_cfg(reg_idx_t idx, logic [31:0] d);
		@(negedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic send_item(logic [15:0] s, logic [15:0] a, logic [23:0] p, logic [15:0] b);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 9) @(negedge clk);
		in_valid <= 1; sample <= s; above_sample <= a; position <= p; band <= b;
		do @(posedge clk); while (in_stall);
		sb.note_item(s, a, p, b);
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// mostly well-formed scan: band sequence with growing positions, some random items mixed in
	task automatic run_scan(int n, int maxval);
		logic [23:0] p;
		p = 24'($urandom_range(3));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 10)
				send_item(16'($urandom), 16'($urandom), 24'($urandom), 16'($urandom));
			else
				send_item(16'($urandom_range(maxval)), 16'($urandom_range(maxval)), p,
					16'(i % 4));
			if (i % 4 == 3)
				p = p + 24'(1 + ($urandom_range(9) == 0 ? $urandom_range(5000) : 0));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, first position, bands beyond the taps
		send_item(16'h0000, 16'h0000, 0, 0);
		send_item(16'hFFFF, 16'h0000, 0, 1);
		send_item(16'h0000, 16'hFFFF, 1, 2);
		send_item(16'hFFFF, 16'hFFFF, 2, 3);
		send_item(16'h8000, 16'h7FFF, 24'hFFFFFF, 16'hFFFF);
		send_item(16'h1234, 16'h1230, 3, 16'h0100);
		send_item(16'hFFFF, 16'h0000, 4, 3);
		send_item(16'h0000, 16'hFFFF, 5, 3);
		send_item(16'h5555, 16'hAAAA, 6, 2);
		send_item(16'hAAAA, 16'h5555, 0, 7);
		drain();
		write_cfg(REG_MAX_ERROR, 255);
		write_cfg(REG_WEIGHT_EXP_MIN, 32'(5'b11010));
		write_cfg(REG_WEIGHT_EXP_MAX, 9);
		write_cfg(REG_WEIGHT_INC_LOG, 4);
		write_cfg(REG_POSITION_OFFSET, 32'h0000FFFF);
		send_item(16'hFFFF, 16'h0000, 1, 3);
		send_item(16'h0000, 16'hFFFF, 2, 3);
		send_item(16'h1000, 16'h0FFF, 24'hFFFFFF, 3);
		send_item(16'h8000, 16'h8000, 100, 1);
		drain();

		// random phases over several register settings
		for (int ph = 0; ph < 6; ph++) begin
			write_cfg(REG_MAX_ERROR, ph == 0 ? 0 : (ph == 1 ? 255 : $urandom_range(20)));
			write_cfg(REG_WEIGHT_EXP_MIN, ph == 2 ? 9 : (ph == 3 ? -6 : $urandom_range(9) - 6));
			write_cfg(REG_WEIGHT_EXP_MAX, ph == 2 ? -6 : (ph == 3 ? 9 : $urandom_range(9)));
			write_cfg(REG_WEIGHT_INC_LOG, ph == 4 ? 11 : (ph == 5 ? 4 : $urandom_range(11, 4)));
			write_cfg(REG_POSITION_OFFSET, ph == 4 ? 0 : $urandom_range(70000) & 16'hFFFF);
			write_cfg(reg_idx_t'(3'd7), $urandom);
			no_idle = (ph == 3);
			if (ph == 1) begin
				fork
					begin
						hold_rx = 1;
						repeat (400) @(posedge clk);
						hold_rx = 0;
					end
					run_scan(110, 65535);
				join
			end else
				run_scan(110, ph[0] ? 65535 : 300);
			no_idle = 0;
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS hyperspectral_adaptive_predictor_top");
		else
			$display("FAIL hyperspectral_adaptive_predictor_top");
		$finish;
	end
endmodule
